// ===== hdl/hhfl_pkg.sv =====
`default_nettype none
package hhfl_pkg;

   localparam longint unsigned MAX_MESSAGE_BYTES = 64'd65536;
   // highest byte position that the 16-bit counters hold
   localparam logic [15:0] POS_LIMIT =
      ((MAX_MESSAGE_BYTES - 64'd1) > 64'hFFFF) ? 16'hFFFF : 16'(MAX_MESSAGE_BYTES - 64'd1);

   localparam int KIND_COUNT  = 11;
   localparam int MAX_PAT_LEN = 19;

   localparam logic [3:0] KIND_HOST    = 4'd0;
   localparam logic [3:0] KIND_CTYPE   = 4'd1;
   localparam logic [3:0] KIND_ACCEPT  = 4'd2;
   localparam logic [3:0] KIND_REFERER = 4'd3;
   localparam logic [3:0] KIND_AGENT   = 4'd4;
   localparam logic [3:0] KIND_CLIENT  = 4'd5;
   localparam logic [3:0] KIND_CENC    = 4'd6;
   localparam logic [3:0] KIND_TENC    = 4'd7;
   localparam logic [3:0] KIND_CLEN    = 4'd8;
   localparam logic [3:0] KIND_COOKIE  = 4'd9;
   localparam logic [3:0] KIND_SESSION = 4'd10;
   localparam logic [3:0] KIND_END     = 4'd11;
   localparam logic [3:0] KIND_TRUNC   = 4'd12;

   localparam logic [4:0] COL_MAX        = 5'd31;
   localparam logic [4:0] COL_HOST_SPACE = 5'd5;
   localparam logic [4:0] COL_BLANK      = 5'd1;
   localparam logic [4:0] COL_FOLD_A     = 5'd0;
   localparam logic [4:0] COL_FOLD_B     = 5'd8;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] FOLD_MASK  = 8'hDF;

   // prefixes right-justified, first character in the highest used byte
   localparam logic [MAX_PAT_LEN*8-1:0] PAT_TEXT [KIND_COUNT] = '{
      "Host:",
      "Content-Type: ",
      "Accept: ",
      "Referer: ",
      "User-Agent: ",
      "User-Client: ",
      "Content-Encoding: ",
      "Transfer-Encoding: ",
      "Content-Length: ",
      "Cookie: ",
      "X-Session-Type: "
   };

   localparam logic [4:0] PAT_LEN [KIND_COUNT] = '{
      5'd5, 5'd14, 5'd8, 5'd9, 5'd12, 5'd13, 5'd18, 5'd19, 5'd16, 5'd8, 5'd16
   };

   localparam logic [4:0] PAT_NEED [KIND_COUNT] = '{
      5'd6, 5'd14, 5'd8, 5'd9, 5'd12, 5'd13, 5'd18, 5'd19, 5'd16, 5'd8, 5'd16
   };

   localparam logic PAT_FOLD [KIND_COUNT] = '{
      1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0
   };

   typedef struct packed {
      logic        valid;
      logic [3:0]  kind;
      logic [15:0] offset;
      logic [15:0] length;
   } hhfl_result_type;

   function automatic logic [7:0] pat_char(input int k, input logic [4:0] col);
      int idx;
      idx = int'(PAT_LEN[k]) - 1 - int'(col);
      if (idx < 0) begin
         return 8'h00;
      end
      return PAT_TEXT[k][idx*8 +: 8];
   endfunction

endpackage
`default_nettype wire

// ===== hdl/hhfl_prefix_match.sv =====
`default_nettype none
module hhfl_prefix_match (
   input  wire logic [7:0]                     data_byte,
   input  wire logic [4:0]                     column,
   output logic      [hhfl_pkg::KIND_COUNT-1:0] mismatch
);
   import hhfl_pkg::*;

   // one compare per prefix against the character at this column
   always_comb begin
      for (int k = 0; k < KIND_COUNT; k++) begin
         if (PAT_FOLD[k] && (column == COL_FOLD_A || column == COL_FOLD_B)) begin
            mismatch[k] = (column < PAT_LEN[k]) &&
                          ((data_byte & FOLD_MASK) != pat_char(k, column));
         end else begin
            mismatch[k] = (column < PAT_LEN[k]) && (data_byte != pat_char(k, column));
         end
      end
   end

endmodule
`default_nettype wire

// ===== hdl/hhfl_core.sv =====
`default_nettype none
module hhfl_core (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   fire,
   input  wire logic [7:0]             data_byte,
   input  wire logic                   last_byte,
   output hhfl_pkg::hhfl_result_type   result
);
   import hhfl_pkg::*;

   localparam logic [KIND_COUNT-1:0] ALL_ALIVE = {KIND_COUNT{1'b1}};

   logic [15:0]           pos_ff, pos_in;
   logic [15:0]           line_start_ff, line_start_in;
   logic [4:0]            col_ff, col_in;
   logic [KIND_COUNT-1:0] alive_ff, alive_in;
   logic                  host_space_ff, host_space_in;
   logic                  prev_cr_ff, prev_cr_in;
   logic                  done_ff, done_in;

   logic [KIND_COUNT-1:0] mismatch;
   logic [15:0]           pos_next;
   logic [15:0]           cr_pos;
   logic [15:0]           line_len;
   logic                  found;
   logic [3:0]            sel;
   logic [4:0]            skip;

   hhfl_prefix_match u_match (
      .data_byte (data_byte),
      .column    (col_ff),
      .mismatch  (mismatch)
   );

   always_comb begin
      pos_next = (pos_ff >= POS_LIMIT) ? POS_LIMIT : pos_ff + 16'd1;
      cr_pos   = (pos_ff != 16'd0) ? pos_ff - 16'd1 : 16'd0;
      line_len = (cr_pos >= line_start_ff) ? cr_pos - line_start_ff : 16'd0;

      // first live prefix in priority order whose line is long enough
      found = 1'b0;
      sel   = KIND_HOST;
      for (int k = 0; k < KIND_COUNT; k++) begin
         if (!found && alive_ff[k] && (line_len > {11'd0, PAT_NEED[k]})) begin
            found = 1'b1;
            sel   = 4'(k);
         end
      end
      skip = PAT_LEN[sel] + {4'd0, (sel == KIND_HOST) && host_space_ff};

      pos_in        = pos_next;
      line_start_in = line_start_ff;
      col_in        = col_ff;
      alive_in      = alive_ff;
      host_space_in = host_space_ff;
      prev_cr_in    = prev_cr_ff;
      done_in       = done_ff;
      result        = '0;

      if (!done_ff) begin
         if (data_byte == CHAR_LF && prev_cr_ff) begin
            if (col_ff == COL_BLANK) begin
               done_in       = 1'b1;
               result.valid  = 1'b1;
               result.kind   = KIND_END;
               result.offset = pos_next;
            end else if (found) begin
               result.valid  = 1'b1;
               result.kind   = sel;
               result.offset = line_start_ff + {11'd0, skip};
               result.length = line_len - {11'd0, skip};
            end
            line_start_in = pos_next;
            col_in        = 5'd0;
            alive_in      = ALL_ALIVE;
            host_space_in = 1'b0;
            prev_cr_in    = 1'b0;
         end else begin
            alive_in = alive_ff & ~mismatch;
            if (col_ff == COL_HOST_SPACE) begin
               host_space_in = (data_byte == CHAR_SPACE);
            end
            col_in     = (col_ff < COL_MAX) ? col_ff + 5'd1 : COL_MAX;
            prev_cr_in = (data_byte == CHAR_CR);
         end
      end

      if (last_byte) begin
         if (!done_in) begin
            result.valid  = 1'b1;
            result.kind   = KIND_TRUNC;
            result.offset = line_start_in;
            result.length = 16'd0;
         end
         pos_in        = 16'd0;
         line_start_in = 16'd0;
         col_in        = 5'd0;
         alive_in      = ALL_ALIVE;
         host_space_in = 1'b0;
         prev_cr_in    = 1'b0;
         done_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= 16'd0;
         line_start_ff <= 16'd0;
         col_ff        <= 5'd0;
         alive_ff      <= ALL_ALIVE;
         host_space_ff <= 1'b0;
         prev_cr_ff    <= 1'b0;
         done_ff       <= 1'b0;
      end else if (fire) begin
         pos_ff        <= pos_in;
         line_start_ff <= line_start_in;
         col_ff        <= col_in;
         alive_ff      <= alive_in;
         host_space_ff <= host_space_in;
         prev_cr_ff    <= prev_cr_in;
         done_ff       <= done_in;
      end
   end

   a_cr_needs_column: assert property (@(posedge clock) disable iff (reset)
      prev_cr_ff |-> (col_ff != 5'd0))
      else $error("cr flag set on an empty line");

   a_host_space_column: assert property (@(posedge clock) disable iff (reset)
      host_space_ff |-> (col_ff > COL_HOST_SPACE))
      else $error("host space flag set before its column");

   a_last_resets: assert property (@(posedge clock) disable iff (reset)
      (fire && last_byte) |=> (pos_ff == 16'd0 && !done_ff && alive_ff == ALL_ALIVE))
      else $error("state not cleared after last byte");

endmodule
`default_nettype wire

// ===== hdl/http_header_field_locator.sv =====
// data path: a transferred byte waits in the input register, then one pass of
// prefix compare loads its result into the result register that drives rsp
// throughput: one byte per cycle unless rsp stalls, zero or one result per byte
// reset: synchronous, active high; clears the parser state and both valid flags
`default_nettype none
module http_header_field_locator (
   input  wire logic        clock,
   input  wire logic        reset,
   // byte channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // data_byte[7:0]
   input  wire logic        req_tlast,   // last_byte
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // value_offset[15:0], value_length[31:16]
   output logic [3:0]       rsp_tuser    // header_kind[3:0]
);
   import hhfl_pkg::*;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [3:0]  rsp_kind_ff;
   logic [15:0] rsp_offset_ff;
   logic [15:0] rsp_length_ff;

   logic            out_free;   // result register empty or draining this cycle
   logic            fire;       // held byte goes through the parser
   logic            req_xfer;
   hhfl_result_type core_res;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_xfer   = req_tvalid && req_tready;

   hhfl_core u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .result    (core_res)
   );

   always_comb begin
      // a new byte refills the input register, otherwise it empties on fire
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      // a waiting result holds until its transfer
      rsp_valid_in = out_free ? (fire && core_res.valid) : 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (fire && core_res.valid) begin
         rsp_kind_ff   <= core_res.kind;
         rsp_offset_ff <= core_res.offset;
         rsp_length_ff <= core_res.length;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_length_ff, rsp_offset_ff};
   assign rsp_tuser  = rsp_kind_ff;

   a_stall_holds_byte: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_free) |=> (in_valid_ff && $stable(in_byte_ff) && $stable(in_last_ff)))
      else $error("held byte lost during result stall");

   a_result_from_fire: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff && !fire) |=> !rsp_valid_ff)
      else $error("result appeared without a parsed byte");

   a_trunc_on_last: assert property (@(posedge clock) disable iff (reset)
      (fire && core_res.valid && core_res.kind == KIND_TRUNC) |-> in_last_ff)
      else $error("truncated result on a byte that is not last");

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
   import hhfl_pkg::*;

   // one located header field as the result channel carries it
   typedef struct packed {
      logic [3:0]  kind;
      logic [15:0] offset;
      logic [15:0] length;
   } field_loc_type;

   // a fixed row check replaces the predicted result of the row's final byte
   typedef struct packed {
      logic          fixed;
      field_loc_type want;
   } row_check_type;

   localparam row_check_type NO_CHECK = '0;
   localparam int NUM_ROWS = 20;

   // text markers in the directed table: newline is a full CR LF pair
   localparam byte MARK_CR   = "~";   // lone carriage return
   localparam byte MARK_LF   = "^";   // lone line feed
   localparam byte MARK_HIGH = "#";   // byte 0xff
   localparam byte MARK_ZERO = "@";   // byte 0x00

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // data_byte[7:0]
   logic        req_tlast  = 1'b0;    // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;            // value_offset[15:0], value_length[31:16]
   logic [3:0]  rsp_tuser;            // header_kind[3:0]

   // random idling on both sides, and the long receiver hold-off
   logic idle_on      = 1'b1;
   logic rx_hold      = 1'b0;
   logic random_phase = 1'b0;

   int mismatch_count = 0;

   // header prefixes indexed by kind code
   string hdr_prefix [KIND_COUNT] = '{
      "Host:", "Content-Type: ", "Accept: ", "Referer: ", "User-Agent: ",
      "User-Client: ", "Content-Encoding: ", "Transfer-Encoding: ",
      "Content-Length: ", "Cookie: ", "X-Session-Type: "
   };

   // parser state mirrored by the predictor
   logic [15:0]           pos_now;
   logic [15:0]           line_base;
   logic [4:0]            line_col;
   logic [KIND_COUNT-1:0] alive_mask;
   logic                  host_gap;
   logic                  saw_cr;
   logic                  hdr_done;

   // expected header fields, oldest first
   field_loc_type expected_fields [$];
   // bytes of the message being built
   logic [7:0] msg_bytes [$];

   // directed table: message text, and the result typed in where it is obvious
   string row_text [NUM_ROWS] = '{
      "\n",
      "A",
      "#\n",
      "@",
      "Host:\n\n",
      "GET / HTTP/1.1\nHost: a.example\n\n",
      "Host:b.example\n\n",
      "Content-Type: text/plain\n\n",
      "content-type: x\ncontent-Type: y\nContent-type: z\nContent-Length: 12\n\n",
      "content-length: 7\nCONTENT-LENGTH: 8\n\n",
      "Accept: */*\nReferer: r\nUser-Agent: ua\nUser-Client: uc\n\n",
      "Content-Encoding: gz\nTransfer-Encoding: ch\nCookie: k=v\nX-Session-Type: s\n\n",
      "Accept: \nAccept: a\nHost: \nHost:x\nHost: xy\n\n",
      "Cookie: a~b^c\n~^\n\n",
      "\nHost: ignored\nAccept: x",
      "Accept: abc\n",
      "User-Agent: aaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaa\n\n",
      "Cookie: #@#\n\n",
      "accept: x\nHOST: y\nUser-Agentx y\nContent-encoding: x\n\n",
      "X-Session-Type: a\nCookie: b"
   };

   row_check_type row_check [NUM_ROWS] = '{
      '{1'b1, '{KIND_END,   16'd2, 16'd0}},   // blank line alone
      '{1'b1, '{KIND_TRUNC, 16'd0, 16'd0}},   // single byte, no blank line
      '{1'b1, '{KIND_TRUNC, 16'd3, 16'd0}},   // top byte value, line ends, no blank line
      '{1'b1, '{KIND_TRUNC, 16'd0, 16'd0}},   // zero byte alone
      '{1'b1, '{KIND_END,   16'd9, 16'd0}},   // bare host prefix gives nothing
      NO_CHECK, NO_CHECK, NO_CHECK, NO_CHECK, NO_CHECK,
      NO_CHECK, NO_CHECK, NO_CHECK, NO_CHECK, NO_CHECK,
      NO_CHECK, NO_CHECK, NO_CHECK, NO_CHECK, NO_CHECK
   };

   http_header_field_locator i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------

   // saturating position step
   function automatic logic [15:0] next_pos(input logic [15:0] p);
      return (p >= POS_LIMIT) ? POS_LIMIT : p + 16'd1;
   endfunction

   // prefix byte compare; content-type and content-length fold case at columns 0 and 8
   function automatic bit prefix_char_ok(input int k, input int col, input logic [7:0] b);
      logic [7:0] want;
      want = hdr_prefix[k][col];
      if ((k == KIND_CTYPE || k == KIND_CLEN) && (col == 0 || col == 8)) begin
         return (b & FOLD_MASK) == want;
      end
      return b == want;
   endfunction

   task automatic start_line();
      line_col   = '0;
      alive_mask = '1;
      host_gap   = 1'b0;
      saw_cr     = 1'b0;
   endtask

   task automatic clear_parser();
      pos_now   = '0;
      line_base = '0;
      hdr_done  = 1'b0;
      start_line();
   endtask

   // advance the mirrored parser by one byte and work out its result, if any
   task automatic locate_field(input logic [7:0] b, input logic last,
                               output bit found, output field_loc_type loc);
      logic [15:0] cr_pos;
      logic [15:0] line_len;
      logic [15:0] skip;
      int          k;
      int          need;
      found = 1'b0;
      loc   = '0;
      if (!hdr_done) begin
         if (b == CHAR_LF && saw_cr) begin
            cr_pos   = (pos_now != 16'd0) ? pos_now - 16'd1 : 16'd0;
            line_len = (cr_pos >= line_base) ? cr_pos - line_base : 16'd0;
            if (line_col == COL_BLANK) begin
               // blank line closes the header block
               hdr_done = 1'b1;
               found    = 1'b1;
               loc      = '{KIND_END, next_pos(pos_now), 16'd0};
            end else begin
               // first live prefix in priority order that the line outgrows
               for (k = 0; k < KIND_COUNT && !found; k++) begin
                  need = hdr_prefix[k].len() + ((k == KIND_HOST) ? 1 : 0);
                  if (alive_mask[k] && int'(line_len) > need) begin
                     skip = 16'(hdr_prefix[k].len());
                     if (k == KIND_HOST && host_gap) begin
                        skip = skip + 16'd1;
                     end
                     found      = 1'b1;
                     loc.kind   = 4'(k);
                     loc.offset = line_base + skip;
                     loc.length = line_len - skip;
                  end
               end
            end
            line_base = next_pos(pos_now);
            start_line();
         end else begin
            for (k = 0; k < KIND_COUNT; k++) begin
               if (int'(line_col) < hdr_prefix[k].len() && !prefix_char_ok(k, line_col, b)) begin
                  alive_mask[k] = 1'b0;
               end
            end
            if (line_col == COL_HOST_SPACE) begin
               host_gap = (b == CHAR_SPACE);
            end
            if (line_col != COL_MAX) begin
               line_col = line_col + 5'd1;
            end
            saw_cr = (b == CHAR_CR);
         end
      end
      pos_now = next_pos(pos_now);
      if (last) begin
         // message ended inside the header block: truncated result wins
         if (!hdr_done) begin
            found = 1'b1;
            loc   = '{KIND_TRUNC, line_base, 16'd0};
         end
         clear_parser();
      end
   endtask

   // ------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string msg);
      if (mismatch_count < 100) begin
         $display("MISMATCH at %0t: %s", $time, msg);
      end
      mismatch_count++;
   endtask

   task automatic check_field(input logic [3:0] kind, input logic [15:0] offset,
                              input logic [15:0] length);
      field_loc_type want;
      if (expected_fields.size() == 0) begin
         report_mismatch($sformatf("unexpected result kind %0d offset %0d length %0d",
                                   kind, offset, length));
         return;
      end
      want = expected_fields.pop_front();
      if (kind !== want.kind) begin
         report_mismatch($sformatf("header_kind %0d, expected %0d", kind, want.kind));
      end
      if (offset !== want.offset) begin
         report_mismatch($sformatf("value_offset %0d, expected %0d (kind %0d)",
                                   offset, want.offset, want.kind));
      end
      if (length !== want.length) begin
         report_mismatch($sformatf("value_length %0d, expected %0d (kind %0d)",
                                   length, want.length, want.kind));
      end
   endtask

   // result side: check each transfer, then pick next cycle's ready
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         check_field(rsp_tuser, rsp_tdata[15:0], rsp_tdata[31:16]);
      end
      rsp_tready <= !rx_hold && !(idle_on && $urandom_range(0, 99) < 29);
   end

   // long receiver hold-off early in the random part, so the block backs up
   initial begin
      wait (random_phase);
      repeat (40) @(posedge clock);
      rx_hold <= 1'b1;
      repeat (300) @(posedge clock);
      rx_hold <= 1'b0;
   end

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------

   // add one byte to the end of the message being built
   task automatic append_byte(input logic [7:0] b);
      msg_bytes.insert(msg_bytes.size(), b);
   endtask

   // offer one byte, wait for its transfer, then record what it should give
   task automatic drive_byte(input logic [7:0] data, input logic last,
                             input row_check_type chk);
      bit            found;
      field_loc_type loc;
      while (idle_on && $urandom_range(0, 99) < 29) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      locate_field(data, last, found, loc);
      if (chk.fixed) begin
         expected_fields.insert(expected_fields.size(), chk.want);
      end else if (found) begin
         expected_fields.insert(expected_fields.size(), loc);
      end
   endtask

   // send the built message with last on its final byte
   task automatic send_message(input row_check_type chk);
      int i;
      int n;
      n = msg_bytes.size();
      for (i = 0; i < n; i++) begin
         drive_byte(msg_bytes[i], i == n - 1, (i == n - 1) ? chk : NO_CHECK);
      end
      msg_bytes.delete();
   endtask

   // append text, expanding the table markers
   task automatic add_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) begin
         case (s[i])
            8'h0A: begin
               append_byte(CHAR_CR);
               append_byte(CHAR_LF);
            end
            MARK_CR:   append_byte(CHAR_CR);
            MARK_LF:   append_byte(CHAR_LF);
            MARK_HIGH: append_byte(8'hFF);
            MARK_ZERO: append_byte(8'h00);
            default:   append_byte(s[i]);
         endcase
      end
   endtask

   // one header line with random content; tame lines are never blank and their random content is printable
   task automatic add_header_line(input bit tame);
      int         k;
      int         i;
      int         n;
      int         cut;
      int         bad_col;
      logic [7:0] c;
      k = $urandom_range(0, KIND_COUNT + 2);
      if (k < KIND_COUNT) begin
         // mostly a well-formed prefix, sometimes cut short or with one bad byte
         cut = hdr_prefix[k].len();
         if ($urandom_range(0, 9) == 0) begin
            cut = $urandom_range(tame ? 1 : 0, cut - 1);
         end
         bad_col = ($urandom_range(0, 9) == 0) ? $urandom_range(0, cut) : -1;
         for (i = 0; i < cut; i++) begin
            c = hdr_prefix[k][i];
            if ((i == 0 || i == 8) && $urandom_range(0, 7) == 0) begin
               c = c ^ 8'h20;   // flip letter case at the folded columns
            end
            if (i == bad_col) begin
               c = c ^ (8'h01 << $urandom_range(0, 6));
            end
            append_byte(c);
         end
         if (k == KIND_HOST && $urandom_range(0, 1) == 1) begin
            append_byte(CHAR_SPACE);
         end
         n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(0, 14);
      end else begin
         n = $urandom_range(tame ? 1 : 0, 40);
      end
      for (i = 0; i < n; i++) begin
         if (!tame && (k >= KIND_COUNT || $urandom_range(0, 15) == 0)) begin
            append_byte(8'($urandom_range(0, 255)));
         end else begin
            append_byte(8'($urandom_range(33, 126)));
         end
      end
      // line ending: mostly CR LF, sometimes a lone LF or a lone CR
      case ($urandom_range(0, 19))
         0:       append_byte(CHAR_LF);
         1:       append_byte(CHAR_CR);
         default: begin
            append_byte(CHAR_CR);
            append_byte(CHAR_LF);
         end
      endcase
   endtask

   // a random request: request line, headers, then a blank line or a broken ending
   task automatic build_request();
      int i;
      int n;
      if ($urandom_range(0, 7) != 0) begin
         add_text("GET /index.html HTTP/1.1\n");
      end
      n = $urandom_range(0, 6);
      for (i = 0; i < n; i++) begin
         add_header_line(1'b0);
      end
      case ($urandom_range(0, 9))
         0: ;   // no blank line at all
         1: begin
            repeat ($urandom_range(1, 5)) append_byte(8'($urandom_range(0, 255)));
         end
         default: begin
            add_text("\n");
            repeat ($urandom_range(0, 6)) append_byte(8'($urandom_range(0, 255)));
         end
      endcase
      if (msg_bytes.size() == 0) begin
         append_byte(8'($urandom_range(0, 255)));
      end
   endtask

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------

   initial begin
      int i;
      int random_bytes;
      int drain;
      clear_parser();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table, with a stretch of rows where neither side idles
      for (i = 0; i < NUM_ROWS; i++) begin
         if (i == 8) begin
            idle_on <= 1'b0;
         end else if (i == 14) begin
            idle_on <= 1'b1;
         end
         add_text(row_text[i]);
         send_message(row_check[i]);
      end

      // random requests
      random_phase = 1'b1;
      random_bytes = 0;
      while (random_bytes < 100) begin
         build_request();
         random_bytes += msg_bytes.size();
         send_message(NO_CHECK);
      end
      req_tvalid <= 1'b0;

      // drain outstanding results, then wait for strays before the final check
      for (drain = 0; drain < 20000 && expected_fields.size() != 0; drain++) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
      if (expected_fields.size() != 0) begin
         report_mismatch($sformatf("%0d expected results never arrived",
                                   expected_fields.size()));
      end

      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // watchdog: ends the test as failed if the main sequence never finishes
   initial begin
      #10000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== http_header_field_locator.f =====
hdl/hhfl_pkg.sv
hdl/hhfl_prefix_match.sv
hdl/hhfl_core.sv
hdl/http_header_field_locator.sv
verif/tb_top.sv
